[design/sqwse_pkg.sv]
// types, codes and small helpers for the square-wave channel with sweep and envelope
// no dependencies; imported by sqwse_sweep_calc and square_wave_channel_sweep_envelope
`default_nettype none

package sqwse_pkg;

	typedef enum logic [2:0] {
		CMD_WRITE    = 3'd0,
		CMD_DUTY     = 3'd1,
		CMD_LENGTH   = 3'd2,
		CMD_SWEEP    = 3'd3,
		CMD_ENVELOPE = 3'd4,
		CMD_READ     = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		REG_SWEEP    = 3'd0,
		REG_DUTY_LEN = 3'd1,
		REG_ENVELOPE = 3'd2,
		REG_FREQ_LO  = 3'd3,
		REG_FREQ_HI  = 3'd4
	} reg_sel_t;

	localparam logic [6:0] LENGTH_FULL = 7'd64;
	localparam logic [3:0] VOLUME_MAX  = 4'd15;
	localparam logic [7:0] DAC_MASK    = 8'hF8;

	// result of one sweep frequency calculation
	typedef struct packed {
		logic        ovf;
		logic [10:0] freq;
	} sweep_res_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [1:0]  duty_sel;
		logic [5:0]  length_load;
		logic [6:0]  length_left;
		logic        length_enable;
		logic        chan_enabled;
		logic        dac_on;
		logic [3:0]  volume;
		logic [3:0]  out_level;
		logic [2:0]  env_period;
		logic        env_up;
		logic [3:0]  env_start_volume;
		logic [3:0]  env_timer;
		logic [2:0]  sweep_period;
		logic        sweep_down;
		logic [2:0]  sweep_shift;
		logic        sweep_on;
		logic [3:0]  sweep_timer;
		logic [10:0] shadow_freq;
		logic [10:0] freq_value;
	} chan_state_t;

	// a zero period counts as eight
	function automatic logic [3:0] timer_reload(input logic [2:0] period);
		timer_reload = (period == 3'd0) ? 4'd8 : {1'b0, period};
	endfunction

	// waveform is high while phase is below 1, 2, 4 or 6 steps
	function automatic logic duty_high(input logic [1:0] sel, input logic [2:0] phase);
		logic [2:0] cnt;
		case (sel)
			2'd0: cnt = 3'd1;
			2'd1: cnt = 3'd2;
			2'd2: cnt = 3'd4;
			default: cnt = 3'd6;
		endcase
		duty_high = (phase < cnt);
	endfunction

endpackage

`default_nettype wire

[design/sqwse_sweep_calc.sv]
// sweep target frequency: shadow plus or minus shadow shifted right, with overflow flag
// uses sqwse_pkg for the result struct
`default_nettype none

module sqwse_sweep_calc (
	input  wire logic [10:0]          shadow,
	input  wire logic [2:0]           shift,
	input  wire logic                 down,
	output sqwse_pkg::sweep_res_t     res
);
	import sqwse_pkg::*;

	logic [11:0] delta;
	logic [11:0] nf;

	assign delta = {1'b0, shadow >> shift};
	assign nf    = down ? ({1'b0, shadow} - delta) : ({1'b0, shadow} + delta);

	assign res.ovf  = nf[11];
	assign res.freq = nf[10:0];

endmodule

`default_nettype wire

[design/square_wave_channel_sweep_envelope.sv]
// top level of the square-wave channel: command decode, channel state and result register
// depends on sqwse_pkg and sqwse_sweep_calc
//
//  channel  | dir | tdata                         | tuser
//  s_*      | in  | [7:0] write_byte              | [2:0] command, [5:3] reg_select
//  m_*      | out | [7:0] sample, [8] channel_on, | none
//           |     | [19:9] frequency, [23:20] zero|
//
// one command per cycle if no result stalls, one result per command, registered to m_tvalid
// the state update and the two chained sweep adders sit between the state and result registers
// reset clears the whole channel state and empties the result register
// while a result is stalled, s_tready stays high only if that result leaves in the same cycle
`default_nettype none

module square_wave_channel_sweep_envelope (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] write_byte
	input  wire logic [5:0]  s_tuser,   // [2:0] command, [5:3] reg_select
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [23:0] m_tdata    // [7:0] sample, [8] channel_on, [19:9] frequency
);
	import sqwse_pkg::*;

	chan_state_t st_q, st_d;
	logic        m_valid_q;
	logic [23:0] m_data_q;

	logic        s_fire;
	logic [2:0]  cmd;
	logic [2:0]  sel;
	logic [7:0]  wb;
	logic [10:0] trig_freq;
	logic [10:0] calc_a_in;
	sweep_res_t  swa, swb;
	logic [7:0]  mag;
	logic [7:0]  sample;

	assign cmd      = s_tuser[2:0];
	assign sel      = s_tuser[5:3];
	assign wb       = s_tdata;
	assign s_tready = !m_valid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	// frequency as a trigger sees it: new high bits from this very write
	assign trig_freq = {wb[2:0], st_q.freq_value[7:0]};
	assign calc_a_in = (cmd == CMD_WRITE) ? trig_freq : st_q.shadow_freq;

	sqwse_sweep_calc u_calc_a (
		.shadow (calc_a_in),
		.shift  (st_q.sweep_shift),
		.down   (st_q.sweep_down),
		.res    (swa)
	);

	// second pass on the freshly written frequency
	sqwse_sweep_calc u_calc_b (
		.shadow (swa.freq),
		.shift  (st_q.sweep_shift),
		.down   (st_q.sweep_down),
		.res    (swb)
	);

	always_comb begin
		st_d = st_q;
		case (cmd)
			CMD_WRITE: begin
				case (sel)
					REG_SWEEP: begin
						st_d.sweep_period = wb[6:4];
						st_d.sweep_down   = wb[3];
						st_d.sweep_shift  = wb[2:0];
					end
					REG_DUTY_LEN: begin
						st_d.duty_sel    = wb[7:6];
						st_d.length_load = wb[5:0];
						st_d.out_level   = (st_q.chan_enabled && st_q.dac_on) ?
							st_q.volume : 4'd0;
					end
					REG_ENVELOPE: begin
						st_d.dac_on           = (wb & DAC_MASK) != 8'd0;
						st_d.env_period       = wb[2:0];
						st_d.env_up           = wb[3];
						st_d.env_start_volume = wb[7:4];
					end
					REG_FREQ_LO: begin
						st_d.freq_value = {st_q.freq_value[10:8], wb};
					end
					REG_FREQ_HI: begin
						st_d.freq_value    = trig_freq;
						st_d.length_enable = wb[6];
						if (wb[7]) begin
							st_d.length_left = LENGTH_FULL - {1'b0, st_q.length_load};
							st_d.volume      = st_q.env_start_volume;
							st_d.env_timer   = {1'b0, st_q.env_period};
							st_d.sweep_on    = (st_q.sweep_period != 3'd0) ||
								(st_q.sweep_shift != 3'd0);
							st_d.sweep_timer = timer_reload(st_q.sweep_period);
							st_d.shadow_freq = trig_freq;
							if ((st_q.sweep_shift != 3'd0) && swa.ovf) begin
								st_d.chan_enabled = 1'b0;
								st_d.out_level    = 4'd0;
							end else begin
								st_d.chan_enabled = 1'b1;
								st_d.out_level    = st_q.dac_on ? st_q.env_start_volume : 4'd0;
							end
						end
					end
					default: begin
					end
				endcase
			end
			CMD_DUTY: begin
				st_d.phase     = st_q.phase + 3'd1;
				st_d.out_level = (st_q.chan_enabled && st_q.dac_on) ? st_q.volume : 4'd0;
			end
			CMD_LENGTH: begin
				if ((st_q.length_left != 7'd0) && st_q.length_enable) begin
					st_d.length_left = st_q.length_left - 7'd1;
					if (st_q.length_left == 7'd1) begin
						st_d.chan_enabled = 1'b0;
						st_d.out_level    = 4'd0;
					end
				end
			end
			CMD_SWEEP: begin
				if (st_q.sweep_timer <= 4'd1) begin
					st_d.sweep_timer = timer_reload(st_q.sweep_period);
					if (st_q.sweep_on && (st_q.sweep_period != 3'd0)) begin
						if (swa.ovf) begin
							st_d.chan_enabled = 1'b0;
							st_d.out_level    = 4'd0;
						end else if (st_q.sweep_shift != 3'd0) begin
							st_d.shadow_freq = swa.freq;
							st_d.freq_value  = swa.freq;
							if (swb.ovf) begin
								st_d.chan_enabled = 1'b0;
								st_d.out_level    = 4'd0;
							end
						end
					end
				end else begin
					st_d.sweep_timer = st_q.sweep_timer - 4'd1;
				end
			end
			CMD_ENVELOPE: begin
				if (st_q.env_timer <= 4'd1) begin
					st_d.env_timer = timer_reload(st_q.env_period);
					if (st_q.env_period != 3'd0) begin
						if (st_q.env_up) begin
							if (st_q.volume < VOLUME_MAX)
								st_d.volume = st_q.volume + 4'd1;
						end else if (st_q.volume != 4'd0) begin
							st_d.volume = st_q.volume - 4'd1;
						end
					end
				end else begin
					st_d.env_timer = st_q.env_timer - 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// level times eight, negated while the duty waveform is low
	assign mag    = {1'b0, st_d.out_level, 3'b000};
	assign sample = duty_high(st_d.duty_sel, st_d.phase) ? mag : (8'd0 - mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				st_q      <= st_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire)
			m_data_q <= {4'd0, st_d.freq_value, st_d.chan_enabled, sample};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// a disabled channel never drives a level
	assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.chan_enabled |-> st_q.out_level == 4'd0)
		else $error("level nonzero while channel disabled");

	// a sweep tick either leaves the frequency alone or moves it together with the shadow
	assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && cmd == CMD_SWEEP |=>
		st_q.freq_value == $past(st_q.freq_value) || st_q.freq_value == st_q.shadow_freq)
		else $error("sweep changed frequency without shadow");

	// an enabled length tick on a running counter takes exactly one off
	assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && cmd == CMD_LENGTH && st_q.length_enable && st_q.length_left != 7'd0 |=>
		st_q.length_left == $past(st_q.length_left) - 7'd1)
		else $error("length counter step wrong");

	// every accepted command leaves a result behind
	assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> m_valid_q)
		else $error("accepted command produced no result");

endmodule

`default_nettype wire
